@@ rtl/lkv_pkg.sv @@
// ----------------------------------------------------------------------------
// lkv_pkg
// Types, codes and defaults shared by the key-value cache, its cells and its
// channel interfaces.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int DEF_ENTRIES    = 32;
    localparam int DEF_KEY_WIDTH  = 32;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int             CFG_W       = 6;
    localparam int             CNT_OUT_W   = 6;
    localparam logic [CFG_W-1:0] MAX_RESET = 6'd32;

    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_RETRIEVE = 2'd1,
        REQ_TAKE     = 2'd2,
        REQ_CLEAR    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_RESOLVE,
        S_UPDATE
    } t_state;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOOK,
        CELL_DOWN,
        CELL_UP,
        CELL_CLEAR
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     load_valid;
    } t_cell_ctl;

endpackage

@@ rtl/lkv_req_if.sv @@
// ----------------------------------------------------------------------------
// lkv_req_if
// Request channel: request kind, key and data with valid/ready.
// ----------------------------------------------------------------------------
interface lkv_req_if
    import lkv_pkg::*;
#(
    parameter int KEY_WIDTH  = DEF_KEY_WIDTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [KEY_WIDTH-1:0]  key;
    logic [DATA_WIDTH-1:0] data;

    modport source (output valid, output req_type, output key, output data, input ready);
    modport sink   (input valid, input req_type, input key, input data, output ready);
endinterface

@@ rtl/lkv_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lkv_rsp_if
// Response channel: one result word per request with valid/ready.
// ----------------------------------------------------------------------------
interface lkv_rsp_if
    import lkv_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) ();
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [DATA_WIDTH-1:0] read_data;
    logic                  evicted;
    logic [DATA_WIDTH-1:0] evicted_data;
    logic [CNT_OUT_W-1:0]  entry_count;
    logic                  full_res;

    modport source (
        output valid, output hit, output read_data, output evicted,
        output evicted_data, output entry_count, output full_res, input ready
    );
    modport sink (
        input valid, input hit, input read_data, input evicted,
        input evicted_data, input entry_count, input full_res, output ready
    );
endinterface

@@ rtl/lkv_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lkv_cfg_if
// Configuration write channel for the entry limit register.
// ----------------------------------------------------------------------------
interface lkv_cfg_if
    import lkv_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] max_entries;

    modport source (output valid, output max_entries, input ready);
    modport sink   (input valid, input max_entries, output ready);
endinterface

@@ rtl/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Key-value store with least-recently-used replacement, built as a chain of
// entry cells kept in recency order.
// ----------------------------------------------------------------------------
// Each request runs through the steps accept, key compare in every cell,
// resolve of the hit position and data, then an update that shifts or clears
// the cell chain as the request needs and writes the result word. The next
// request is accepted in the cycle after the update. The update step waits
// while an earlier result word has not been taken. The limit register may be
// written at any time the block is idle and is always ready.
// ----------------------------------------------------------------------------
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int ENTRIES    = DEF_ENTRIES,
    parameter int KEY_WIDTH  = DEF_KEY_WIDTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lkv_req_if.sink     req,
    lkv_rsp_if.source   rsp,
    lkv_cfg_if.sink     cfg
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CMP_W-1:0] ENT_CMP = CMP_W'(ENTRIES);

    t_state r_state, n_state;

    logic [1:0]            r_req;
    logic [KEY_WIDTH-1:0]  r_key;
    logic [DATA_WIDTH-1:0] r_data;
    logic [CFG_W-1:0]      r_max;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_hit;
    logic [IDX_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_hit_data;
    logic [DATA_WIDTH-1:0] r_lru_data;

    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [DATA_WIDTH-1:0] r_out_read_data;
    logic                  r_out_evicted;
    logic [DATA_WIDTH-1:0] r_out_evicted_data;
    logic [CNT_OUT_W-1:0]  r_out_count;
    logic                  r_out_full;

    t_cell_ctl             cell_ctl;
    logic [IDX_W-1:0]      cell_pos;
    logic [DATA_WIDTH-1:0] load_data;
    logic                  upd_en;
    logic                  ev;
    logic                  res_hit;
    logic [DATA_WIDTH-1:0] res_rd;
    logic [DATA_WIDTH-1:0] res_evd;
    logic [CMP_W-1:0]      eff_max;
    logic                  at_max;

    logic [KEY_WIDTH-1:0]  c_key        [ENTRIES];
    logic [DATA_WIDTH-1:0] c_data       [ENTRIES];
    logic                  c_valid      [ENTRIES];
    logic                  c_match      [ENTRIES];
    logic [IDX_W-1:0]      c_match_idx  [ENTRIES];
    logic [DATA_WIDTH-1:0] c_match_data [ENTRIES];
    logic [DATA_WIDTH-1:0] c_last_data  [ENTRIES];

    logic                  any_match;
    logic [IDX_W-1:0]      or_idx;
    logic [DATA_WIDTH-1:0] or_match_data;
    logic [DATA_WIDTH-1:0] or_last_data;

    // cell chain
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [KEY_WIDTH-1:0]  prev_key;
        logic [DATA_WIDTH-1:0] prev_data;
        logic                  prev_valid;
        logic [KEY_WIDTH-1:0]  next_key;
        logic [DATA_WIDTH-1:0] next_data;
        logic                  next_valid;

        if (g == 0) begin : g_head
            assign prev_key   = r_key;
            assign prev_data  = load_data;
            assign prev_valid = 1'b1;
        end else begin : g_mid
            assign prev_key   = c_key[g-1];
            assign prev_data  = c_data[g-1];
            assign prev_valid = c_valid[g-1];
        end

        if (g == ENTRIES - 1) begin : g_tail
            assign next_key   = '0;
            assign next_data  = '0;
            assign next_valid = 1'b0;
        end else begin : g_body
            assign next_key   = c_key[g+1];
            assign next_data  = c_data[g+1];
            assign next_valid = c_valid[g+1];
        end

        lkv_cell #(
            .KEY_WIDTH  (KEY_WIDTH),
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (IDX_W),
            .CNT_W      (CNT_W),
            .CELL_INDEX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_pos        (cell_pos),
            .i_count      (r_count),
            .i_look_key   (r_key),
            .i_prev_key   (prev_key),
            .i_prev_data  (prev_data),
            .i_prev_valid (prev_valid),
            .i_next_key   (next_key),
            .i_next_data  (next_data),
            .i_next_valid (next_valid),
            .o_key        (c_key[g]),
            .o_data       (c_data[g]),
            .o_valid      (c_valid[g]),
            .o_match      (c_match[g]),
            .o_match_idx  (c_match_idx[g]),
            .o_match_data (c_match_data[g]),
            .o_last_data  (c_last_data[g])
        );
    end

    // at most one cell matches and one is last, so plain or-merge
    always_comb begin
        any_match     = 1'b0;
        or_idx        = '0;
        or_match_data = '0;
        or_last_data  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            any_match     = any_match | c_match[i];
            or_idx        = or_idx | c_match_idx[i];
            or_match_data = or_match_data | c_match_data[i];
            or_last_data  = or_last_data | c_last_data[i];
        end
    end

    always_comb begin
        if (r_max == '0) begin
            eff_max = CMP_W'(1);
        end else if (CMP_W'(r_max) > ENT_CMP) begin
            eff_max = ENT_CMP;
        end else begin
            eff_max = CMP_W'(r_max);
        end
    end

    assign at_max = CMP_W'(r_count) >= eff_max;
    assign upd_en = !r_out_valid || rsp.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (req.valid) n_state = S_LOOK;
            S_LOOK:    n_state = S_RESOLVE;
            S_RESOLVE: n_state = S_UPDATE;
            S_UPDATE:  if (upd_en) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // outputs and chain commands
    always_comb begin
        cell_ctl.op         = CELL_HOLD;
        cell_ctl.load_valid = 1'b1;
        cell_pos            = r_pos;
        load_data           = r_hit_data;
        n_count             = r_count;
        ev                  = 1'b0;
        res_hit             = 1'b0;
        res_rd              = '0;
        res_evd             = '0;
        case (r_state)
            S_LOOK: begin
                cell_ctl.op = CELL_LOOK;
            end
            S_UPDATE: begin
                case (t_req'(r_req))
                    REQ_INSERT: begin
                        load_data = r_data;
                        if (r_hit) begin
                            cell_pos = r_pos;
                        end else if (at_max) begin
                            ev       = 1'b1;
                            res_evd  = r_lru_data;
                            cell_pos = IDX_W'(r_count - CNT_W'(1));
                        end else begin
                            cell_pos = IDX_W'(r_count);
                            n_count  = r_count + CNT_W'(1);
                        end
                        if (upd_en) cell_ctl.op = CELL_DOWN;
                    end
                    REQ_RETRIEVE: begin
                        res_hit = r_hit;
                        res_rd  = r_hit ? r_hit_data : '0;
                        if (upd_en && r_hit) cell_ctl.op = CELL_DOWN;
                    end
                    REQ_TAKE: begin
                        res_hit = r_hit;
                        res_rd  = r_hit ? r_hit_data : '0;
                        if (r_hit) n_count = r_count - CNT_W'(1);
                        if (upd_en && r_hit) cell_ctl.op = CELL_UP;
                    end
                    REQ_CLEAR: begin
                        n_count = '0;
                        if (upd_en) cell_ctl.op = CELL_CLEAR;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_max       <= MAX_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg.valid) r_max <= cfg.max_entries;
            if (r_state == S_UPDATE && upd_en) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && req.valid) begin
            r_req  <= req.req_type;
            r_key  <= req.key;
            r_data <= req.data;
        end
        if (r_state == S_RESOLVE) begin
            r_hit      <= any_match;
            r_pos      <= or_idx;
            r_hit_data <= or_match_data;
            r_lru_data <= or_last_data;
        end
        if (r_state == S_UPDATE && upd_en) begin
            r_out_hit          <= res_hit;
            r_out_read_data    <= res_rd;
            r_out_evicted      <= ev;
            r_out_evicted_data <= res_evd;
            r_out_count        <= CNT_OUT_W'(n_count);
            r_out_full         <= CMP_W'(n_count) >= eff_max;
        end
    end

    assign req.ready        = (r_state == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign rsp.valid        = r_out_valid;
    assign rsp.hit          = r_out_hit;
    assign rsp.read_data    = r_out_read_data;
    assign rsp.evicted      = r_out_evicted;
    assign rsp.evicted_data = r_out_evicted_data;
    assign rsp.entry_count  = r_out_count;
    assign rsp.full_res     = r_out_full;

endmodule

@@ rtl/lkv_cell.sv @@
// ----------------------------------------------------------------------------
// lkv_cell
// One entry of the recency-ordered chain: cell n holds the entry of rank n.
// Compares the lookup key and shifts towards either neighbour on command.
// ----------------------------------------------------------------------------
module lkv_cell
    import lkv_pkg::*;
#(
    parameter int KEY_WIDTH  = DEF_KEY_WIDTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int IDX_W      = 5,
    parameter int CNT_W      = 6,
    parameter int CELL_INDEX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [IDX_W-1:0]      i_pos,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [KEY_WIDTH-1:0]  i_look_key,
    input  logic [KEY_WIDTH-1:0]  i_prev_key,
    input  logic [DATA_WIDTH-1:0] i_prev_data,
    input  logic                  i_prev_valid,
    input  logic [KEY_WIDTH-1:0]  i_next_key,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    input  logic                  i_next_valid,
    output logic [KEY_WIDTH-1:0]  o_key,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_valid,
    output logic                  o_match,
    output logic [IDX_W-1:0]      o_match_idx,
    output logic [DATA_WIDTH-1:0] o_match_data,
    output logic [DATA_WIDTH-1:0] o_last_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_INDEX + 1);

    logic [KEY_WIDTH-1:0]  r_key;
    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_valid;
    logic                  r_match;
    logic                  r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            case (i_ctl.op)
                CELL_LOOK: begin
                    r_match <= r_valid && (r_key == i_look_key);
                    r_last  <= r_valid && (i_count == MY_CNT);
                end
                CELL_DOWN: begin
                    if (MY_IDX <= i_pos) begin
                        r_key   <= i_prev_key;
                        r_data  <= i_prev_data;
                        r_valid <= (CELL_INDEX == 0) ? i_ctl.load_valid : i_prev_valid;
                    end
                end
                CELL_UP: begin
                    if (MY_IDX >= i_pos) begin
                        r_key   <= i_next_key;
                        r_data  <= i_next_data;
                        r_valid <= i_next_valid;
                    end
                end
                CELL_CLEAR: begin
                    r_valid <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_key        = r_key;
    assign o_data       = r_data;
    assign o_valid      = r_valid;
    assign o_match      = r_match;
    assign o_match_idx  = r_match ? MY_IDX : '0;
    assign o_match_data = r_match ? r_data : '0;
    assign o_last_data  = r_last ? r_data : '0;

endmodule
